>>> rtl/gshare_tournament_branch_predictor_core_macros.svh
// assertion macros for the branch predictor checker
// no dependencies
`ifndef GSHARE_TOURNAMENT_BRANCH_PREDICTOR_CORE_MACROS_SVH
`define GSHARE_TOURNAMENT_BRANCH_PREDICTOR_CORE_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define GTBP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define GTBP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/gtbp_pkg.sv
// shared types and constants for the branch predictor
// no dependencies
package gtbp_pkg;

   typedef enum logic [1:0] {
      MODE_STATIC = 2'd0,
      MODE_GSHARE = 2'd1,
      MODE_TOURN  = 2'd2,
      MODE_CUSTOM = 2'd3
   } mode_type;

   localparam logic [1:0] CSR_MODE  = 2'd0;
   localparam logic [1:0] CSR_GBITS = 2'd1;
   localparam logic [1:0] CSR_LBITS = 2'd2;
   localparam logic [1:0] CSR_PBITS = 2'd3;

   localparam logic [1:0] CTR_WEAK_NT = 2'd1;
   localparam logic [1:0] CTR_WEAK_G  = 2'd2;
   localparam logic [1:0] CTR_MAX     = 2'd3;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_LOCAL,
      ST_RESOLVE,
      ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic clear_en;
      logic capture;
      logic read_hist;
      logic read_tables;
      logic resolve;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_done;
      logic is_tourn;
   } sts_type;

   function automatic logic [1:0] bump(input logic [1:0] c, input logic taken);
      logic [1:0] r;
      if (taken) r = (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
      else       r = (c == 2'd0) ? 2'd0 : c - 2'd1;
      return r;
   endfunction

endpackage

>>> rtl/gtbp_ram.sv
// generic single write port ram with registered read
// no dependencies
module gtbp_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule

>>> rtl/gtbp_ctrl.sv
// controller state machine for the branch predictor
// depends on gtbp_pkg
module gtbp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  gtbp_pkg::sts_type sts,
   output gtbp_pkg::cmd_type cmd
);
   import gtbp_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:   if (sts.clear_done) state_in = ST_IDLE;
         ST_IDLE:    if (req_valid) state_in = ST_LOOKUP;
         ST_LOOKUP:  state_in = sts.is_tourn ? ST_LOCAL : ST_RESOLVE;
         ST_LOCAL:   state_in = ST_RESOLVE;
         ST_RESOLVE: state_in = ST_OUT;
         ST_OUT:     if (rsp_ready) state_in = ST_IDLE;
         default:    state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_CLEAR:   cmd.clear_en = 1'b1;
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.capture = req_valid;
            cmd.read_hist = req_valid;
         end
         ST_LOOKUP:  cmd.read_tables = 1'b1;
         ST_LOCAL:   ;
         ST_RESOLVE: cmd.resolve = 1'b1;
         ST_OUT:     rsp_valid = 1'b1;
         default:    ;
      endcase
   end
endmodule

>>> rtl/gtbp_dp.sv
// datapath: history and counter tables, prediction and training
// depends on gtbp_pkg and gtbp_ram
module gtbp_dp #(
   parameter int MAX_GLOBAL_BITS = 13,
   parameter int MAX_LOCAL_BITS  = 10,
   parameter int MAX_PC_BITS     = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  gtbp_pkg::cmd_type cmd,
   output gtbp_pkg::sts_type sts,
   input  logic              csr_write,
   input  logic [1:0]        csr_index,
   input  logic [3:0]        csr_data,
   input  logic              req_op,
   input  logic [31:0]       req_pc,
   input  logic              req_outcome,
   output logic              rsp_prediction
);
   import gtbp_pkg::*;

   localparam int GW = MAX_GLOBAL_BITS;
   localparam int LW = MAX_LOCAL_BITS;
   localparam int PW = MAX_PC_BITS;
   localparam int CW = (GW > LW) ? ((GW > PW) ? GW : PW) : ((LW > PW) ? LW : PW);

   function automatic logic [CW-1:0] mask_of(input logic [3:0] bits, input int maxb);
      logic [CW-1:0] m;
      for (int i = 0; i < CW; i++) m[i] = (i < int'(bits)) && (i < maxb);
      return m;
   endfunction

   mode_type mode_ff;
   logic [3:0] gbits_ff, lbits_ff, pbits_ff;
   logic [GW-1:0] ghist_ff;
   logic op_ff, outc_ff, pred_ff;
   logic [GW-1:0] gidx_ff, pcg_ff;
   logic [PW-1:0] pidx_ff;
   logic [LW-1:0] lidx_ff;
   logic [CW:0] clr_ff;

   logic [GW-1:0] gm;
   logic [LW-1:0] lm;
   logic [PW-1:0] pm;
   assign gm = GW'(mask_of(gbits_ff, GW));
   assign lm = LW'(mask_of(lbits_ff, LW));
   assign pm = PW'(mask_of(pbits_ff, PW));

   logic [1:0] gsh_q, loc_q, glb_q, cho_q;
   logic [LW-1:0] lh_q;
   logic gsh_we, loc_we, glb_we, cho_we, lh_we;
   logic [GW-1:0] g_wa, g_ra;
   logic [LW-1:0] l_wa;
   logic [PW-1:0] p_wa;
   logic [1:0] gsh_wd, loc_wd, glb_wd, cho_wd;
   logic [LW-1:0] lh_wd;
   logic lpred, gpred;

   assign sts.clear_done = clr_ff[CW];
   assign sts.is_tourn   = (mode_ff == MODE_TOURN);
   assign lpred = loc_q[1];
   assign gpred = glb_q[1];
   // tournament global and chooser tables are indexed by the history alone
   assign g_ra  = cmd.read_tables ? (ghist_ff & gm) : gidx_ff;

   // gshare read index and tournament global index share the read port timing
   logic [GW-1:0] gsh_ra;
   assign gsh_ra = (ghist_ff & gm) ^ (pcg_ff & gm);

   always_comb begin
      gsh_we = 1'b0; loc_we = 1'b0; glb_we = 1'b0; cho_we = 1'b0; lh_we = 1'b0;
      g_wa = gidx_ff; l_wa = lidx_ff; p_wa = pidx_ff;
      gsh_wd = bump(gsh_q, outc_ff);
      glb_wd = bump(glb_q, outc_ff);
      loc_wd = bump(loc_q, outc_ff);
      lh_wd  = {lh_q[LW-2:0], outc_ff} & lm;
      cho_wd = cho_q;
      if (gpred == outc_ff && lpred != outc_ff && cho_q != CTR_MAX) cho_wd = cho_q + 2'd1;
      else if (gpred != outc_ff && lpred == outc_ff && cho_q != 2'd0) cho_wd = cho_q - 2'd1;
      if (cmd.clear_en) begin
         gsh_we = 1'b1; loc_we = 1'b1; glb_we = 1'b1; cho_we = 1'b1; lh_we = 1'b1;
         g_wa = clr_ff[GW-1:0]; l_wa = clr_ff[LW-1:0]; p_wa = clr_ff[PW-1:0];
         gsh_wd = CTR_WEAK_NT; loc_wd = CTR_WEAK_NT; glb_wd = CTR_WEAK_NT;
         cho_wd = CTR_WEAK_G; lh_wd = '0;
      end else if (cmd.resolve && op_ff) begin
         gsh_we = (mode_ff == MODE_GSHARE);
         if (mode_ff == MODE_TOURN) begin
            loc_we = 1'b1; glb_we = 1'b1; cho_we = 1'b1; lh_we = 1'b1;
         end
      end
   end

   gtbp_ram #(.WIDTH(2), .DEPTH(1 << GW)) u_gsh (.clock, .we(gsh_we), .waddr(g_wa),
      .wdata(gsh_wd), .raddr(cmd.read_tables ? gsh_ra : gidx_ff), .rdata(gsh_q));
   gtbp_ram #(.WIDTH(2), .DEPTH(1 << GW)) u_glb (.clock, .we(glb_we), .waddr(g_wa),
      .wdata(glb_wd), .raddr(g_ra), .rdata(glb_q));
   gtbp_ram #(.WIDTH(2), .DEPTH(1 << GW)) u_cho (.clock, .we(cho_we), .waddr(g_wa),
      .wdata(cho_wd), .raddr(g_ra), .rdata(cho_q));
   gtbp_ram #(.WIDTH(LW), .DEPTH(1 << PW)) u_lh (.clock, .we(lh_we), .waddr(p_wa),
      .wdata(lh_wd), .raddr(cmd.read_hist ? req_pc[PW-1:0] & pm : pidx_ff), .rdata(lh_q));
   gtbp_ram #(.WIDTH(2), .DEPTH(1 << LW)) u_loc (.clock, .we(loc_we), .waddr(l_wa),
      .wdata(loc_wd), .raddr(cmd.read_tables ? lh_q & lm : lidx_ff), .rdata(loc_q));

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_GSHARE;
         gbits_ff <= 4'd13; lbits_ff <= 4'd10; pbits_ff <= 4'd10;
         ghist_ff <= '0;
         clr_ff <= '0;
      end else begin
         if (cmd.clear_en) clr_ff <= clr_ff + 1'b1;
         if (csr_write) begin
            unique case (csr_index)
               CSR_MODE:  mode_ff  <= mode_type'(csr_data[1:0]);
               CSR_GBITS: gbits_ff <= csr_data;
               CSR_LBITS: lbits_ff <= csr_data;
               CSR_PBITS: pbits_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.resolve && op_ff) begin
            if (mode_ff == MODE_GSHARE) ghist_ff <= {ghist_ff[GW-2:0], outc_ff};
            else if (mode_ff == MODE_TOURN) ghist_ff <= {ghist_ff[GW-2:0], outc_ff} & gm;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= req_op; outc_ff <= req_outcome;
         pcg_ff <= req_pc[GW-1:0];
         pidx_ff <= req_pc[PW-1:0] & pm;
      end
      if (cmd.read_tables) begin
         gidx_ff <= (mode_ff == MODE_GSHARE) ? gsh_ra : (ghist_ff & gm);
         lidx_ff <= lh_q & lm;
      end
      if (cmd.resolve) begin
         unique case (mode_ff)
            MODE_STATIC: pred_ff <= 1'b1;
            MODE_GSHARE: pred_ff <= gsh_q[1];
            MODE_TOURN:  pred_ff <= (cho_q < CTR_WEAK_G) ? lpred : gpred;
            MODE_CUSTOM: pred_ff <= 1'b0;
            default:     pred_ff <= 1'b0;
         endcase
      end
   end

   assign rsp_prediction = pred_ff;
endmodule

>>> rtl/gshare_tournament_branch_predictor_core.sv
// top level of the gshare and tournament branch predictor
// depends on gtbp_pkg, gtbp_ctrl, gtbp_dp
//
// One word in gives one prediction word out. The block handles one word at a
// time: after accept it passes the lookup, resolve and output states, with a
// local state between lookup and resolve in tournament mode, and it re-arms in
// idle after the result is taken. The tournament path is longer because the
// local history must be read from its memory before the local counter memory
// can be addressed. After reset a clearing pass sets every table to its
// initial value; req_ready stays low until it ends, while csr writes are taken
// at any time. Width settings saturate at their maximum; a width of zero uses
// entry zero.
module gshare_tournament_branch_predictor_core #(
   parameter int MAX_GLOBAL_BITS = 13,
   parameter int MAX_LOCAL_BITS  = 10,
   parameter int MAX_PC_BITS     = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [31:0] req_pc,
   input  logic        req_outcome,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_prediction,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [3:0]  csr_data
);
   import gtbp_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencer
   gtbp_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .sts, .cmd
   );

   // tables, histories and prediction logic
   gtbp_dp #(
      .MAX_GLOBAL_BITS(MAX_GLOBAL_BITS),
      .MAX_LOCAL_BITS(MAX_LOCAL_BITS),
      .MAX_PC_BITS(MAX_PC_BITS)
   ) u_dp (
      .clock, .reset, .cmd, .sts, .csr_write, .csr_index, .csr_data,
      .req_op, .req_pc, .req_outcome, .rsp_prediction
   );
endmodule

>>> rtl/gtbp_checker.sv
// port-level checker for the branch predictor, bound to the top level
// depends on the macros header
`include "gshare_tournament_branch_predictor_core_macros.svh"
module gtbp_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_prediction
);
   `GTBP_ASSERT_IMPL(a_no_overlap, clock, reset, rsp_valid, !req_ready, "accept while result pending")
   `GTBP_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_prediction), "result dropped")
   `GTBP_ASSERT_NEXT(a_busy, clock, reset, req_valid && req_ready, !req_ready && !rsp_valid, "no gap after accept")
endmodule

bind gshare_tournament_branch_predictor_core gtbp_checker u_chk (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .rsp_prediction
);

>>> sim/tb.sv
// self-checking testbench for the gshare and tournament branch predictor
// depends on gtbp_pkg and gshare_tournament_branch_predictor_core
// drives predict and train words in all modes and a range of width settings, checks every prediction
module tb;
   import gtbp_pkg::*;

   localparam int GBITS = 13;
   localparam int LBITS = 10;
   localparam int PBITS = 10;
   localparam int GSZ = 1 << GBITS;
   localparam int LSZ = 1 << LBITS;
   localparam int PSZ = 1 << PBITS;
   localparam int WATCHDOG_LIMIT = 40000;

   typedef struct packed {
      logic        op;
      logic [31:0] pc;
      logic        outcome;
   } branch_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_op = 1'b0;
   logic [31:0] req_pc = '0;
   logic        req_outcome = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_prediction;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = CSR_MODE;
   logic [3:0]  csr_data = '0;

   gshare_tournament_branch_predictor_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_op(req_op),
      .req_pc(req_pc), .req_outcome(req_outcome),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_prediction(rsp_prediction),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state mirrored here
   mode_type    pm_mode;
   logic [3:0]  pm_gbits, pm_lbits, pm_pbits;
   logic [12:0] pm_ghist;
   logic [1:0]  pm_gshare [GSZ];
   logic [9:0]  pm_lhist  [PSZ];
   logic [1:0]  pm_lctr   [LSZ];
   logic [1:0]  pm_gctr   [GSZ];
   logic [1:0]  pm_choose [GSZ];

   branch_word_type pending_words[$];
   logic            expected_preds[$];

   int  mismatches = 0;
   int  checked = 0;
   int  accepted = 0;
   int  idle_cycles = 0;
   bit  timed_out = 0;
   bit  quiet = 0;            // no idling in the final stretch
   int  rsp_hold = 0;         // long receiver hold-off request
   int  sent_per_mode[4];

   function automatic logic [12:0] width_mask(input logic [3:0] bits, input int maxbits);
      int b;
      b = (bits > maxbits) ? maxbits : bits;
      return 13'((32'd1 << b) - 1);
   endfunction

   function automatic logic [1:0] sat_step(input logic [1:0] c, input logic taken);
      if (taken) return (c == 2'd3) ? 2'd3 : c + 2'd1;
      return (c == 2'd0) ? 2'd0 : c - 2'd1;
   endfunction

   task automatic predictor_reset();
      pm_mode = MODE_GSHARE;
      pm_gbits = 4'd13; pm_lbits = 4'd10; pm_pbits = 4'd10;
      pm_ghist = '0;
      for (int i = 0; i < GSZ; i++) begin
         pm_gshare[i] = 2'd1; pm_gctr[i] = 2'd1; pm_choose[i] = 2'd2;
      end
      for (int i = 0; i < LSZ; i++) pm_lctr[i] = 2'd1;
      for (int i = 0; i < PSZ; i++) pm_lhist[i] = '0;
   endtask

   // computes the prediction for one word and applies its training
   function automatic logic predict_and_train(input branch_word_type w);
      logic [12:0] gm, lm, pmask, gidx, idx;
      logic [9:0]  pidx, lidx;
      logic        lp, gp, p;
      gm = width_mask(pm_gbits, GBITS);
      lm = width_mask(pm_lbits, LBITS);
      pmask = width_mask(pm_pbits, PBITS);
      gidx = pm_ghist & gm;
      p = 1'b0;
      case (pm_mode)
         MODE_STATIC: p = 1'b1;
         MODE_GSHARE: begin
            idx = gidx ^ (w.pc[12:0] & gm);
            p = pm_gshare[idx] > 2'd1;
            if (w.op) begin
               pm_gshare[idx] = sat_step(pm_gshare[idx], w.outcome);
               pm_ghist = {pm_ghist[11:0], w.outcome};
            end
         end
         MODE_TOURN: begin
            pidx = w.pc[9:0] & pmask[9:0];
            lidx = pm_lhist[pidx] & lm[9:0];
            lp = pm_lctr[lidx] > 2'd1;
            gp = pm_gctr[gidx] > 2'd1;
            p = (pm_choose[gidx] < 2'd2) ? lp : gp;
            if (w.op) begin
               if (gp == w.outcome && lp != w.outcome) begin
                  if (pm_choose[gidx] != 2'd3) pm_choose[gidx] = pm_choose[gidx] + 2'd1;
               end else if (gp != w.outcome && lp == w.outcome) begin
                  if (pm_choose[gidx] != 2'd0) pm_choose[gidx] = pm_choose[gidx] - 2'd1;
               end
               pm_gctr[gidx] = sat_step(pm_gctr[gidx], w.outcome);
               pm_lctr[lidx] = sat_step(pm_lctr[lidx], w.outcome);
               pm_lhist[pidx] = {pm_lhist[pidx][8:0], w.outcome} & lm[9:0];
               pm_ghist = {pm_ghist[11:0], w.outcome} & gm;
            end
         end
         default: p = 1'b0;
      endcase
      return p;
   endfunction

   // driver: offers queued words, random idle bursts between them
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_preds.push_back(predict_and_train(
               branch_word_type'{req_op, req_pc, req_outcome}));
            sent_per_mode[pm_mode]++;
            accepted++;
            void'(pending_words.pop_front());
         end
         if (req_valid && !req_ready) begin
            // hold the word
         end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            send_gap <= $urandom_range(0, 3);
            req_valid <= 1'b0;
         end else if (pending_words.size() > (req_valid && req_ready ? 0 : 0)) begin
            req_valid <= 1'b1;
            req_op <= pending_words[0].op;
            req_pc <= pending_words[0].pc;
            req_outcome <= pending_words[0].outcome;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: random stall bursts, compares each prediction word
   int stall_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_preds.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected prediction word %0b", rsp_prediction);
            end else begin
               logic exp_p;
               exp_p = expected_preds.pop_front();
               checked++;
               if (exp_p !== rsp_prediction) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("prediction mismatch #%0d: expected %0b actual %0b",
                              checked, exp_p, rsp_prediction);
               end
            end
         end
         if (rsp_hold > 0) begin
            rsp_hold <= rsp_hold - 1;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 3);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d predictions outstanding",
                  expected_preds.size());
         $display("tb NOT OK");
         $finish;
      end
   end

   task automatic csr_put(input logic [1:0] idx, input logic [3:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_MODE:  pm_mode = mode_type'(val[1:0]);
         CSR_GBITS: pm_gbits = val;
         CSR_LBITS: pm_lbits = val;
         default:   pm_pbits = val;
      endcase
   endtask

   task automatic drain();
      while (pending_words.size() != 0 || expected_preds.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [31:0] random_pc(input int pool);
      // small pool of branch sites for history reuse, sometimes any address
      if ($urandom_range(0, 7) == 0) return $urandom;
      return 32'(($urandom_range(0, pool) << 2) ^ ($urandom_range(0, 1) << 31));
   endfunction

   task automatic queue_word(input logic op, input logic [31:0] pc, input logic outcome);
      pending_words.push_back(branch_word_type'{op, pc, outcome});
   endtask

   // biased loop-like branches so counters and histories move deep
   task automatic queue_random(input int n);
      int site;
      for (int i = 0; i < n; i++) begin
         site = $urandom_range(0, 15);
         queue_word($urandom_range(0, 7) != 0, random_pc(site * 7 + 40),
                    site[0] ? ($urandom_range(0, 7) != 0) : 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      logic [3:0] widths[4];
      for (int m = 0; m < 4; m++) sent_per_mode[m] = 0;
      predictor_reset();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: every mode, extremes of pc, both outcomes and ops
      foreach (widths[k]) begin
         csr_put(CSR_MODE, 4'(k));
         queue_word(1'b0, 32'h0000_0000, 1'b0);
         queue_word(1'b1, 32'hFFFF_FFFF, 1'b1);
         queue_word(1'b1, 32'hFFFF_FFFF, 1'b1);
         queue_word(1'b1, 32'hAAAA_5555, 1'b0);
         queue_word(1'b1, 32'h5555_AAAA, 1'b1);
         drain();
      end
      // width registers at zero and above their maxima in tournament mode
      csr_put(CSR_MODE, 4'(MODE_TOURN));
      csr_put(CSR_GBITS, 4'd0); csr_put(CSR_LBITS, 4'd15); csr_put(CSR_PBITS, 4'd0);
      for (int i = 0; i < 3; i++) queue_word(1'b1, 32'h1234_5678, i[0]);
      drain();
      csr_put(CSR_GBITS, 4'd15); csr_put(CSR_LBITS, 4'd0); csr_put(CSR_PBITS, 4'd15);
      for (int i = 0; i < 3; i++) queue_word(1'b1, 32'h8765_4321, 1'b1);
      drain();

      // random phases over modes and widths, extremes included
      for (int ph = 0; ph < 14; ph++) begin
         csr_put(CSR_MODE, (ph < 12) ? ((ph % 3 == 2) ? 4'($urandom_range(0, 3))
                                        : 4'(1 + ph % 2)) : 4'(MODE_TOURN));
         widths[1] = (ph % 4 == 0) ? 4'd1 : (ph % 4 == 1) ? 4'd13 : 4'($urandom_range(0, 15));
         widths[2] = (ph % 5 == 0) ? 4'd1 : (ph % 5 == 1) ? 4'd10 : 4'($urandom_range(0, 15));
         widths[3] = (ph % 3 == 0) ? 4'd1 : (ph % 3 == 1) ? 4'd10 : 4'($urandom_range(0, 15));
         csr_put(CSR_GBITS, widths[1]);
         csr_put(CSR_LBITS, widths[2]);
         csr_put(CSR_PBITS, widths[3]);
         if (ph == 3) begin
            rsp_hold = 60;
            queue_random(100);
         end else begin
            if (ph == 13) quiet = 1;
            queue_random(100);
         end
         drain();   // sender pauses until everything has come back
      end

      $display("covered %0d words: static %0d, gshare %0d, tournament %0d, custom %0d",
               accepted, sent_per_mode[0], sent_per_mode[1], sent_per_mode[2],
               sent_per_mode[3]);
      $display("%0d predictions checked, %0d mismatches", checked, mismatches);
      if (mismatches == 0 && expected_preds.size() == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end
endmodule

>>> filelist.f
+incdir+rtl
rtl/gtbp_pkg.sv
rtl/gtbp_ram.sv
rtl/gtbp_ctrl.sv
rtl/gtbp_dp.sv
rtl/gshare_tournament_branch_predictor_core.sv
rtl/gtbp_checker.sv
sim/tb.sv
